// ===== hw/rtl/cbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Cone box filter steering package
// Shared types, register and count indexes, steering codes and helpers.
// ----------------------------------------------------------------------------
package cbfs_pkg;

	localparam int unsigned IMAGE_WIDTH = 640;
	localparam logic signed [12:0] MID_X = 13'(IMAGE_WIDTH / 2);

	// Iterative divider geometry.
	localparam int unsigned DIV_NUM_W = 32;
	localparam int unsigned DIV_DEN_W = 16;

	typedef enum logic {
		OP_BOX = 1'b0,
		OP_EOF = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [9:0] x;
		logic [9:0] y;
		logic [9:0] w;
		logic [9:0] h;
	} item_t;

	typedef struct packed {
		logic [9:0]  horizon_row;
		logic [9:0]  top_row;
		logic [8:0]  track_margin;
		logic [8:0]  steer_margin;
		logic [9:0]  min_size;
		logic [15:0] max_size;
		logic [15:0] min_aspect;
		logic [15:0] max_aspect;
	} cfg_t;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_HORIZON_ROW  = 3'd0;
	localparam logic [2:0] REG_TOP_ROW      = 3'd1;
	localparam logic [2:0] REG_TRACK_MARGIN = 3'd2;
	localparam logic [2:0] REG_STEER_MARGIN = 3'd3;
	localparam logic [2:0] REG_MIN_SIZE     = 3'd4;
	localparam logic [2:0] REG_MAX_SIZE     = 3'd5;
	localparam logic [2:0] REG_MIN_ASPECT   = 3'd6;
	localparam logic [2:0] REG_MAX_ASPECT   = 3'd7;

	// Steering codes.
	localparam logic [2:0] STEER_STRAIGHT     = 3'd0;
	localparam logic [2:0] STEER_SLIGHT_LEFT  = 3'd1;
	localparam logic [2:0] STEER_SLIGHT_RIGHT = 3'd2;
	localparam logic [2:0] STEER_SHARP_LEFT   = 3'd3;
	localparam logic [2:0] STEER_SHARP_RIGHT  = 3'd4;

	// Frame count indexes, in result order.
	localparam int unsigned NUM_COUNTS = 6;
	localparam int unsigned CNT_TOTAL  = 0;
	localparam int unsigned CNT_VIEW   = 1;
	localparam int unsigned CNT_SIZED  = 2;
	localparam int unsigned CNT_CONE   = 3;
	localparam int unsigned CNT_LEFT   = 4;
	localparam int unsigned CNT_RIGHT  = 5;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

// ===== hw/rtl/cbfs_if.sv =====
// ----------------------------------------------------------------------------
// Cone box filter steering channels
// Valid/ready channels for box items and steering results.
// ----------------------------------------------------------------------------
interface cbfs_item_if;
	logic             valid;
	logic             ready;
	cbfs_pkg::op_t    operation;
	logic [9:0]       box_x;
	logic [9:0]       box_y;
	logic [9:0]       box_w;
	logic [9:0]       box_h;

	modport source(output valid, operation, box_x, box_y, box_w, box_h, input ready);
	modport sink(input valid, operation, box_x, box_y, box_w, box_h, output ready);
endinterface

interface cbfs_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] steer_code;
	logic       lost;
	logic [7:0] total_count;
	logic [7:0] in_view_count;
	logic [7:0] sized_count;
	logic [7:0] cone_count;
	logic [7:0] left_count;
	logic [7:0] right_count;

	modport source(output valid, steer_code, lost, total_count, in_view_count, sized_count,
		cone_count, left_count, right_count, input ready);
	modport sink(input valid, steer_code, lost, total_count, in_view_count, sized_count,
		cone_count, left_count, right_count, output ready);
endinterface

// ===== hw/rtl/cone_box_filter_steering_core.sv =====
// ----------------------------------------------------------------------------
// Cone box filter steering core
// Per-frame box filtering and steering decision with an APB register port.
// ----------------------------------------------------------------------------
// Boxes enter through a two-entry queue and are handled one at a time by a
// back end built around a shared 32-step serial divider. A box dropped by the
// view band needs no division. A box below the horizon takes two size divisions
// and one aspect division (only the size divisions when the size limits drop
// it). A box at or above the horizon takes one aspect division (none when the
// size limits drop it). An end-of-frame transaction needs no division when the
// decision needs no arithmetic, and three divisions and a multiply when both
// nearest cones are projected, plus any wait for the output register. Results
// wait in an output register, so boxes keep flowing while a result is not
// taken, until the next end-of-frame transaction needs that register.
// Configuration must be written only while the core is idle; the core itself
// does not enforce this.
module cone_box_filter_steering_core (
	input  logic        clk,
	input  logic        arst_n,
	cbfs_item_if.sink   item,
	cbfs_result_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cbfs_pkg::cfg_t  cfg_q;
	cbfs_pkg::item_t q_item;
	logic            q_valid;
	logic            q_pop;
	logic [2:0]      reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.horizon_row  <= 10'd240;
			cfg_q.top_row      <= 10'd180;
			cfg_q.track_margin <= 9'd32;
			cfg_q.steer_margin <= 9'd32;
			cfg_q.min_size     <= 10'd4;
			cfg_q.max_size     <= 16'd200;
			cfg_q.min_aspect   <= 16'd50;
			cfg_q.max_aspect   <= 16'd300;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				cbfs_pkg::REG_HORIZON_ROW:  cfg_q.horizon_row  <= pwdata[9:0];
				cbfs_pkg::REG_TOP_ROW:      cfg_q.top_row      <= pwdata[9:0];
				cbfs_pkg::REG_TRACK_MARGIN: cfg_q.track_margin <= pwdata[8:0];
				cbfs_pkg::REG_STEER_MARGIN: cfg_q.steer_margin <= pwdata[8:0];
				cbfs_pkg::REG_MIN_SIZE:     cfg_q.min_size     <= pwdata[9:0];
				cbfs_pkg::REG_MAX_SIZE:     cfg_q.max_size     <= pwdata[15:0];
				cbfs_pkg::REG_MIN_ASPECT:   cfg_q.min_aspect   <= pwdata[15:0];
				cbfs_pkg::REG_MAX_ASPECT:   cfg_q.max_aspect   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cbfs_pkg::REG_HORIZON_ROW:  prdata = {22'b0, cfg_q.horizon_row};
			cbfs_pkg::REG_TOP_ROW:      prdata = {22'b0, cfg_q.top_row};
			cbfs_pkg::REG_TRACK_MARGIN: prdata = {23'b0, cfg_q.track_margin};
			cbfs_pkg::REG_STEER_MARGIN: prdata = {23'b0, cfg_q.steer_margin};
			cbfs_pkg::REG_MIN_SIZE:     prdata = {22'b0, cfg_q.min_size};
			cbfs_pkg::REG_MAX_SIZE:     prdata = {16'b0, cfg_q.max_size};
			cbfs_pkg::REG_MIN_ASPECT:   prdata = {16'b0, cfg_q.min_aspect};
			cbfs_pkg::REG_MAX_ASPECT:   prdata = {16'b0, cfg_q.max_aspect};
			default:                    prdata = 32'd0;
		endcase
	end

	cbfs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	cbfs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.result  (result)
	);

`ifndef SYNTHESIS
	// Each filter stage can only pass on what the stage before it counted.
	a_count_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.left_count <= result.cone_count &&
			result.right_count <= result.cone_count &&
			result.cone_count <= result.sized_count &&
			result.sized_count <= result.in_view_count &&
			result.in_view_count <= result.total_count))
		else $error("frame counts out of order");

	// A fresh steering decision needs at least two cones.
	a_found_cones: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.lost) |-> (result.cone_count >= 8'd2))
		else $error("steering decided with fewer than two cones");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.steer_code <= cbfs_pkg::STEER_SHARP_RIGHT))
		else $error("steering code out of range");
`endif

endmodule

// ===== hw/rtl/cbfs_front.sv =====
// ----------------------------------------------------------------------------
// Cone box filter front end
// Accepts items with their box or end-of-frame tag and queues up to two of them.
// ----------------------------------------------------------------------------
module cbfs_front (
	input  logic               clk,
	input  logic               arst_n,
	cbfs_item_if.sink          item,
	output cbfs_pkg::item_t    q_item,
	output logic               q_valid,
	input  logic               q_pop
);

	cbfs_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;
	cbfs_pkg::item_t in_item;

	assign item.ready = (count_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign q_valid    = (count_q != 2'd0);
	assign pop        = q_pop && q_valid;
	assign q_item     = mem_q[rd_ptr_q];

	always_comb begin
		in_item.op = item.operation;
		in_item.x  = item.box_x;
		in_item.y  = item.box_y;
		in_item.w  = item.box_w;
		in_item.h  = item.box_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

endmodule

// ===== hw/rtl/cbfs_div.sv =====
// ----------------------------------------------------------------------------
// Cone box filter divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbfs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cbfs_pkg::DIV_NUM_W-1:0]  num,
	input  logic [cbfs_pkg::DIV_DEN_W-1:0]  den,
	output logic                            done,
	output logic [cbfs_pkg::DIV_NUM_W-1:0]  quo
);

	localparam int unsigned NW = cbfs_pkg::DIV_NUM_W;
	localparam int unsigned DW = cbfs_pkg::DIV_DEN_W;
	localparam int unsigned CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   diff;
	logic          qbit;
	logic [DW-1:0] rem_nxt;

	assign rem_sh  = {rem_q, quo_q[NW-1]};
	assign diff    = rem_sh - {1'b0, den_q};
	assign qbit    = (rem_sh >= {1'b0, den_q});
	assign rem_nxt = qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
	assign done    = done_q;
	assign quo     = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(NW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

endmodule

// ===== hw/rtl/cbfs_back.sv =====
// ----------------------------------------------------------------------------
// Cone box filter back end
// Filters boxes, tracks near and far cones, and decides steering per frame.
// ----------------------------------------------------------------------------
module cbfs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cbfs_pkg::cfg_t     cfg,
	input  cbfs_pkg::item_t    q_item,
	input  logic               q_valid,
	output logic               q_pop,
	cbfs_result_if.source      result
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WDIV,
		ST_HDIV,
		ST_CHK,
		ST_ADIV,
		ST_LDIV,
		ST_RDIV,
		ST_MUL,
		ST_MSTART,
		ST_MDIV,
		ST_OUT
	} state_t;

	state_t      st_q;
	logic [9:0]  x_q, y_q, w_q, h_q;
	logic [19:0] wadj_q, hadj_q;
	logic        neg_q;
	logic signed [21:0] lxp_q, rxp_q;
	logic signed [32:0] prod_q;
	logic [2:0]  code_q;
	logic        lost_q;

	logic [9:0]  nlx_q, nlw_q, nly_q, flx_q, fly_q;
	logic [9:0]  nrx_q, nry_q, frx_q, fry_q;
	logic [7:0]  cnt_q [cbfs_pkg::NUM_COUNTS];
	logic [2:0]  last_steer_q;

	logic        res_valid_q;
	logic [2:0]  res_code_q;
	logic        res_lost_q;
	logic [7:0]  res_cnt_q [cbfs_pkg::NUM_COUNTS];

	logic        div_start;
	logic        div_start_q;
	logic [31:0] div_num_q;
	logic [15:0] div_den_q;
	logic        div_done;
	logic [31:0] div_quo;

	logic [9:0]  hr;
	logic [10:0] band_sum;
	logic [19:0] quo_floor;
	logic [10:0] cx;
	logic signed [12:0] cx_s, lim_l, lim_r;
	logic        size_fail;
	logic        asp_fail;

	logic        lv, rv;
	logic        early_done;
	logic        early_lost;
	logic [2:0]  early_code;

	logic signed [12:0] off_l, off_r;
	logic [11:0] offl_mag, offr_mag;
	logic signed [10:0] dl, dr;
	logic [9:0]  dl_mag, dr_mag;
	logic        negl, negr;
	logic [21:0] numl, numr;
	logic signed [21:0] quo_signed;

	logic signed [22:0] sum, sum_rnd;
	logic signed [21:0] half;
	logic [9:0]  aim;
	logic signed [10:0] scale;
	logic signed [32:0] prod_n;
	logic [31:0] prod_mag;
	logic signed [32:0] mq;
	logic signed [32:0] sm_s;

	cbfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign hr       = cfg.horizon_row;
	assign q_pop    = (st_q == ST_IDLE);
	assign band_sum = {1'b0, q_item.y} + {2'b0, q_item.h[9:1]};
	assign quo_floor = (div_quo == 32'd0) ? 20'd1 : div_quo[19:0];

	// Size and aspect limits.
	assign size_fail = (wadj_q < {10'b0, cfg.min_size}) || (hadj_q < {10'b0, cfg.min_size}) ||
		(wadj_q > {4'b0, cfg.max_size}) || (hadj_q > {4'b0, cfg.max_size});
	assign asp_fail  = (div_quo < {16'b0, cfg.min_aspect}) ||
		(div_quo > {16'b0, cfg.max_aspect});

	// Side assignment by center column; limits may fall outside the image.
	assign cx    = {1'b0, x_q} + {2'b0, w_q[9:1]};
	assign cx_s  = $signed({2'b0, cx});
	assign lim_l = cbfs_pkg::MID_X - $signed({4'b0, cfg.track_margin});
	assign lim_r = cbfs_pkg::MID_X + $signed({4'b0, cfg.track_margin});

	assign lv = (cnt_q[cbfs_pkg::CNT_LEFT] != 8'd0);
	assign rv = (cnt_q[cbfs_pkg::CNT_RIGHT] != 8'd0);

	always_comb begin
		early_done = 1'b1;
		early_lost = 1'b0;
		early_code = cbfs_pkg::STEER_STRAIGHT;
		if (cnt_q[cbfs_pkg::CNT_CONE] < 8'd2 || (!lv && !rv)) begin
			early_lost = 1'b1;
			early_code = last_steer_q;
		end else if (!lv) begin
			early_code = (nrx_q > frx_q) ? cbfs_pkg::STEER_SHARP_LEFT : cbfs_pkg::STEER_SHARP_RIGHT;
		end else if (!rv) begin
			early_code = (nlx_q > flx_q) ? cbfs_pkg::STEER_SHARP_LEFT : cbfs_pkg::STEER_SHARP_RIGHT;
		end else if (nly_q > fry_q) begin
			early_code = cbfs_pkg::STEER_SHARP_LEFT;
		end else if (nry_q > fly_q) begin
			early_code = cbfs_pkg::STEER_SHARP_RIGHT;
		end else if (hr == 10'd0) begin
			early_code = cbfs_pkg::STEER_STRAIGHT;
		end else begin
			early_done = 1'b0;
		end
	end

	// A division starts in the cycle after the state that loads its operands.
	always_comb begin
		div_start = 1'b0;
		case (st_q)
			ST_IDLE: div_start = q_valid && ((q_item.op == cbfs_pkg::OP_EOF) ? !early_done :
				((band_sum <= {1'b0, cfg.top_row}) && (q_item.y < hr)));
			ST_WDIV, ST_LDIV: div_start = div_done;
			ST_CHK: div_start = !size_fail;
			ST_MSTART: div_start = 1'b1;
			default: div_start = 1'b0;
		endcase
	end

	// Perspective offsets of the nearest cones, split into sign and magnitude.
	assign off_l    = $signed({3'b0, nlx_q}) + $signed({3'b0, nlw_q}) - cbfs_pkg::MID_X;
	assign off_r    = $signed({3'b0, nrx_q}) - cbfs_pkg::MID_X;
	assign offl_mag = off_l[12] ? 12'(-off_l) : off_l[11:0];
	assign offr_mag = off_r[12] ? 12'(-off_r) : off_r[11:0];
	assign dl       = $signed({1'b0, hr}) - $signed({1'b0, nly_q});
	assign dr       = $signed({1'b0, hr}) - $signed({1'b0, nry_q});
	assign dl_mag   = (dl == 11'sd0) ? 10'd1 : (dl[10] ? 10'(-dl) : dl[9:0]);
	assign dr_mag   = (dr == 11'sd0) ? 10'd1 : (dr[10] ? 10'(-dr) : dr[9:0]);
	assign negl     = off_l[12] ^ dl[10];
	assign negr     = off_r[12] ^ dr[10];
	assign numl     = {10'b0, offl_mag} * {12'b0, hr};
	assign numr     = {10'b0, offr_mag} * {12'b0, hr};
	assign quo_signed = neg_q ? -$signed({1'b0, div_quo[20:0]}) : $signed({1'b0, div_quo[20:0]});

	// Midpoint offset: half the sum, truncated toward zero, scaled to the aim row.
	assign sum      = $signed({lxp_q[21], lxp_q}) + $signed({rxp_q[21], rxp_q});
	assign sum_rnd  = sum + $signed({22'd0, sum[22]});
	assign half     = sum_rnd[22:1];
	assign aim      = (nly_q < nry_q) ? nly_q : nry_q;
	assign scale    = $signed({1'b0, hr}) - $signed({1'b0, aim});
	assign prod_n   = 33'(half) * 33'(scale);
	assign prod_mag = prod_q[32] ? 32'(-prod_q) : prod_q[31:0];
	assign mq       = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign sm_s     = $signed({24'b0, cfg.steer_margin});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			x_q <= '0; y_q <= '0; w_q <= '0; h_q <= '0;
			wadj_q       <= '0;
			hadj_q       <= '0;
			neg_q        <= 1'b0;
			lxp_q        <= '0;
			rxp_q        <= '0;
			prod_q       <= '0;
			code_q       <= cbfs_pkg::STEER_STRAIGHT;
			lost_q       <= 1'b0;
			nlx_q <= '0; nlw_q <= '0; nly_q <= '0; flx_q <= '0; fly_q <= '0;
			nrx_q <= '0; nry_q <= '0; frx_q <= '0; fry_q <= '0;
			for (int i = 0; i < cbfs_pkg::NUM_COUNTS; i++) begin
				cnt_q[i]     <= '0;
				res_cnt_q[i] <= '0;
			end
			last_steer_q <= cbfs_pkg::STEER_STRAIGHT;
			res_valid_q  <= 1'b0;
			res_code_q   <= cbfs_pkg::STEER_STRAIGHT;
			res_lost_q   <= 1'b0;
			div_start_q  <= 1'b0;
			div_num_q    <= '0;
			div_den_q    <= '0;
		end else begin
			div_start_q <= div_start;
			if (res_valid_q && result.ready && st_q != ST_OUT) res_valid_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.op == cbfs_pkg::OP_EOF) begin
							if (early_done) begin
								code_q <= early_code;
								lost_q <= early_lost;
								st_q   <= ST_OUT;
							end else begin
								div_num_q   <= {10'b0, numl};
								div_den_q   <= {6'b0, dl_mag};
								neg_q       <= negl;
								st_q        <= ST_LDIV;
							end
						end else begin
							x_q <= q_item.x; y_q <= q_item.y;
							w_q <= q_item.w; h_q <= q_item.h;
							cnt_q[cbfs_pkg::CNT_TOTAL] <= cbfs_pkg::sat_inc(cnt_q[cbfs_pkg::CNT_TOTAL]);
							if (band_sum <= {1'b0, cfg.top_row}) begin
								cnt_q[cbfs_pkg::CNT_VIEW] <= cbfs_pkg::sat_inc(cnt_q[cbfs_pkg::CNT_VIEW]);
								if (q_item.y >= hr) begin
									// At or above the horizon both sizes scale to one.
									wadj_q <= 20'd1;
									hadj_q <= 20'd1;
									st_q   <= ST_CHK;
								end else begin
									div_num_q   <= {12'b0, {10'b0, q_item.w} * {10'b0, hr}};
									div_den_q   <= {6'b0, hr - q_item.y};
									st_q        <= ST_WDIV;
								end
							end
						end
					end
				end
				ST_WDIV: begin
					if (div_done) begin
						wadj_q      <= quo_floor;
						div_num_q   <= {12'b0, {10'b0, h_q} * {10'b0, hr}};
						div_den_q   <= {6'b0, hr - y_q};
						st_q        <= ST_HDIV;
					end
				end
				ST_HDIV: begin
					if (div_done) begin
						hadj_q <= quo_floor;
						st_q   <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (size_fail) begin
						st_q <= ST_IDLE;
					end else begin
						div_num_q   <= {16'b0, hadj_q[15:0]} * 32'd100;
						div_den_q   <= wadj_q[15:0];
						st_q        <= ST_ADIV;
					end
				end
				ST_ADIV: begin
					if (div_done) begin
						st_q <= ST_IDLE;
						if (!asp_fail) begin
							cnt_q[cbfs_pkg::CNT_SIZED] <= cbfs_pkg::sat_inc(cnt_q[cbfs_pkg::CNT_SIZED]);
							if (cx_s < lim_l) begin
								if (!lv || y_q < nly_q) begin
									nlx_q <= x_q; nlw_q <= w_q; nly_q <= y_q;
								end
								if (y_q > fly_q) begin
									flx_q <= x_q; fly_q <= y_q;
								end
								cnt_q[cbfs_pkg::CNT_CONE] <= cbfs_pkg::sat_inc(cnt_q[cbfs_pkg::CNT_CONE]);
								cnt_q[cbfs_pkg::CNT_LEFT] <= cbfs_pkg::sat_inc(cnt_q[cbfs_pkg::CNT_LEFT]);
							end else if (cx_s >= lim_r) begin
								if (!rv || y_q < nry_q) begin
									nrx_q <= x_q; nry_q <= y_q;
								end
								if (y_q > fry_q) begin
									frx_q <= x_q; fry_q <= y_q;
								end
								cnt_q[cbfs_pkg::CNT_CONE]  <= cbfs_pkg::sat_inc(cnt_q[cbfs_pkg::CNT_CONE]);
								cnt_q[cbfs_pkg::CNT_RIGHT] <= cbfs_pkg::sat_inc(cnt_q[cbfs_pkg::CNT_RIGHT]);
							end
						end
					end
				end
				ST_LDIV: begin
					if (div_done) begin
						lxp_q       <= quo_signed;
						div_num_q   <= {10'b0, numr};
						div_den_q   <= {6'b0, dr_mag};
						neg_q       <= negr;
						st_q        <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						rxp_q <= quo_signed;
						st_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= prod_n;
					st_q   <= ST_MSTART;
				end
				ST_MSTART: begin
					div_num_q   <= prod_mag;
					div_den_q   <= {6'b0, hr};
					neg_q       <= prod_q[32];
					st_q        <= ST_MDIV;
				end
				ST_MDIV: begin
					if (div_done) begin
						lost_q <= 1'b0;
						if (mq > sm_s) code_q <= cbfs_pkg::STEER_SLIGHT_RIGHT;
						else if (mq < -sm_s) code_q <= cbfs_pkg::STEER_SLIGHT_LEFT;
						else code_q <= cbfs_pkg::STEER_STRAIGHT;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q  <= 1'b1;
						res_code_q   <= code_q;
						res_lost_q   <= lost_q;
						last_steer_q <= code_q;
						for (int i = 0; i < cbfs_pkg::NUM_COUNTS; i++) begin
							res_cnt_q[i] <= cnt_q[i];
							cnt_q[i]     <= '0;
						end
						nlx_q <= '0; nlw_q <= '0; nly_q <= '0; flx_q <= '0; fly_q <= '0;
						nrx_q <= '0; nry_q <= '0; frx_q <= '0; fry_q <= '0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid         = res_valid_q;
	assign result.steer_code    = res_code_q;
	assign result.lost          = res_lost_q;
	assign result.total_count   = res_cnt_q[cbfs_pkg::CNT_TOTAL];
	assign result.in_view_count = res_cnt_q[cbfs_pkg::CNT_VIEW];
	assign result.sized_count   = res_cnt_q[cbfs_pkg::CNT_SIZED];
	assign result.cone_count    = res_cnt_q[cbfs_pkg::CNT_CONE];
	assign result.left_count    = res_cnt_q[cbfs_pkg::CNT_LEFT];
	assign result.right_count   = res_cnt_q[cbfs_pkg::CNT_RIGHT];

endmodule
